@@ hw/rtl/sparse_matrix_vector_multiply_assert.svh @@
// -----------------------------------------------------------------------------
// sparse_matrix_vector_multiply_assert.svh
// assertion macros used by the sparse matrix-vector multiply top module
// -----------------------------------------------------------------------------
`ifndef SPARSE_MATRIX_VECTOR_MULTIPLY_ASSERT_SVH
`define SPARSE_MATRIX_VECTOR_MULTIPLY_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SMVM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define SMVM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/smvm_pkg.sv @@
// -----------------------------------------------------------------------------
// smvm_pkg
// shared types and constants of the sparse matrix-vector multiply block
// -----------------------------------------------------------------------------
package smvm_pkg;

    localparam int DEF_VECTOR_DEPTH = 1024;

    localparam int OPCODE_W  = 2;
    localparam int INDEX_W   = 10;
    localparam int VALUE_W   = 32;
    localparam int ROW_W     = 16;
    localparam int RESULT_W  = 64;
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 80;

    typedef enum logic [OPCODE_W-1:0] {
        OP_LOAD      = 2'd0,
        OP_NONZERO   = 2'd1,
        OP_EMPTY_ROW = 2'd2
    } t_opcode;

    // request handed from the read stage to the multiply-accumulate unit
    typedef struct packed {
        logic valid;
        logic empty_row;
        logic last;
        logic in_range;
    } t_mac_req;

endpackage

@@ hw/rtl/sparse_matrix_vector_multiply.sv @@
// -----------------------------------------------------------------------------
// sparse_matrix_vector_multiply
// y = A*x for a matrix streamed in compressed row order, q16.16 in, q32.32 out
// -----------------------------------------------------------------------------
// pipeline: read stage, product and result registers lie before o_m_tvalid
// throughput: one input beat per cycle while o_s_tready is high; the saturating
//   add of the row accumulator and the one-read one-write vector ram set it
// reset: clears the pipeline valids, the row accumulator and the row counter;
//   the vector ram is not cleared and needs no clearing pass
// -----------------------------------------------------------------------------
`include "sparse_matrix_vector_multiply_assert.svh"

module sparse_matrix_vector_multiply #(
    parameter int VECTOR_DEPTH = smvm_pkg::DEF_VECTOR_DEPTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // slave side
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [smvm_pkg::S_TDATA_W-1:0]   i_s_tdata,  // index[9:0], value[41:10]
    input  logic [smvm_pkg::OPCODE_W-1:0]    i_s_tuser,  // opcode[1:0]
    input  logic                             i_s_tlast,  // last_in_row
    // master side
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [smvm_pkg::M_TDATA_W-1:0]   o_m_tdata   // row_index[15:0], row_result[79:16]
);
    import smvm_pkg::*;

    localparam int AW = $clog2(VECTOR_DEPTH);

    // input field unpacking
    t_opcode                   w_op;
    logic [INDEX_W-1:0]        w_index;
    logic signed [VALUE_W-1:0] w_value;
    logic [31:0]               w_idx_ext;
    logic                      w_in_range;
    logic [AW-1:0]             w_addr;

    assign w_op       = t_opcode'(i_s_tuser);
    assign w_index    = i_s_tdata[INDEX_W-1:0];
    assign w_value    = i_s_tdata[INDEX_W +: VALUE_W];
    assign w_idx_ext  = 32'(w_index);
    // indexes past the vector depth: loads dropped, nonzeros read zero
    assign w_in_range = w_idx_ext < 32'(VECTOR_DEPTH);
    assign w_addr     = w_idx_ext[AW-1:0];

    // read stage: holds the item while its vector entry comes out of the ram
    t_mac_req                  r_s1;
    logic signed [VALUE_W-1:0] r_s1_value;
    t_mac_req                  n_s1;

    logic                      w_mac_ready;
    logic                      w_s1_adv;
    logic                      w_accept;
    logic                      w_ram_wr;
    logic                      w_ram_rd;
    logic [VALUE_W-1:0]        w_ram_data;

    assign w_s1_adv   = !r_s1.valid || w_mac_ready;
    assign o_s_tready = w_s1_adv;
    assign w_accept   = i_s_tvalid && w_s1_adv;

    // ram write and read both land at the accept edge, so a nonzero right
    // after a load of the same entry sees the new value without forwarding
    assign w_ram_wr = w_accept && (w_op == OP_LOAD) && w_in_range;
    assign w_ram_rd = w_accept && (w_op == OP_NONZERO);

    always_comb begin
        n_s1           = '0;
        n_s1.valid     = w_accept && (w_op == OP_NONZERO || w_op == OP_EMPTY_ROW);
        n_s1.empty_row = (w_op == OP_EMPTY_ROW);
        n_s1.last      = i_s_tlast;
        n_s1.in_range  = w_in_range;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
        end else if (w_s1_adv) begin
            r_s1 <= n_s1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_value <= w_value;
        end
    end

    // dense vector store
    smvm_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (VECTOR_DEPTH)
    ) u_vec_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_ram_wr),
        .i_wr_addr (w_addr),
        .i_wr_data (w_value),
        .i_rd_en   (w_ram_rd),
        .i_rd_addr (w_addr),
        .o_rd_data (w_ram_data)
    );

    // multiply, accumulate and result register
    logic [ROW_W-1:0]           w_row_index;
    logic signed [RESULT_W-1:0] w_row_result;

    smvm_mac u_mac (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (r_s1),
        .i_mat        (r_s1_value),
        .i_vec        (w_ram_data),
        .o_ready      (w_mac_ready),
        .o_valid      (o_m_tvalid),
        .i_taken      (i_m_tready),
        .o_row_index  (w_row_index),
        .o_row_result (w_row_result)
    );

    assign o_m_tdata = {w_row_result, w_row_index};

    // checks
    `SMVM_ASSERT_NEXT(a_load_no_stage, w_accept && w_op == OP_LOAD, !r_s1.valid,
        "load entered the read stage")
    `SMVM_ASSERT_NEXT(a_s1_hold, r_s1.valid && !w_mac_ready,
        r_s1.valid && $stable(r_s1_value), "read stage lost its item under stall")
    `SMVM_ASSERT_NOW(a_row_step, (o_m_tvalid && i_m_tready) ##1 o_m_tvalid,
        o_m_tdata[15:0] == 16'($past(o_m_tdata[15:0]) + 16'd1),
        "row numbers of back-to-back results do not step by one")

endmodule

@@ hw/rtl/smvm_ram.sv @@
// -----------------------------------------------------------------------------
// smvm_ram
// generic single-write single-read ram with registered read data
// -----------------------------------------------------------------------------
module smvm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hw/rtl/smvm_mac.sv @@
// -----------------------------------------------------------------------------
// smvm_mac
// product register, saturating row accumulator, row counter and result register
// -----------------------------------------------------------------------------
module smvm_mac (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  smvm_pkg::t_mac_req                i_req,
    input  logic signed [smvm_pkg::VALUE_W-1:0]  i_mat,
    input  logic signed [smvm_pkg::VALUE_W-1:0]  i_vec,
    output logic                              o_ready,
    output logic                              o_valid,
    input  logic                              i_taken,
    output logic [smvm_pkg::ROW_W-1:0]        o_row_index,
    output logic signed [smvm_pkg::RESULT_W-1:0] o_row_result
);
    import smvm_pkg::*;

    localparam logic signed [RESULT_W-1:0] ACC_MAX = {1'b0, {(RESULT_W-1){1'b1}}};
    localparam logic signed [RESULT_W-1:0] ACC_MIN = {1'b1, {(RESULT_W-1){1'b0}}};

    logic                       r_s2_valid;
    logic                       r_s2_empty;
    logic                       r_s2_last;
    logic signed [RESULT_W-1:0] r_prod;
    logic signed [RESULT_W-1:0] r_acc;
    logic [ROW_W-1:0]           r_row;
    logic                       r_out_valid;
    logic [ROW_W-1:0]           r_out_row;
    logic signed [RESULT_W-1:0] r_out_res;

    logic signed [VALUE_W-1:0]  w_x;
    logic signed [RESULT_W-1:0] w_prod;
    logic signed [RESULT_W-1:0] w_raw_sum;
    logic signed [RESULT_W-1:0] w_sum;
    logic                       w_s2_emit;
    logic                       w_out_free;
    logic                       w_s2_adv;
    logic                       w_do_acc;
    logic signed [RESULT_W-1:0] n_acc;

    assign w_x    = i_req.in_range ? i_vec : '0;
    assign w_prod = i_mat * w_x;

    // saturating add: overflow only when both signs agree and the sum flips
    assign w_raw_sum = r_acc + r_prod;
    always_comb begin
        w_sum = w_raw_sum;
        if (r_acc[RESULT_W-1] == r_prod[RESULT_W-1] &&
            w_raw_sum[RESULT_W-1] != r_prod[RESULT_W-1]) begin
            w_sum = r_prod[RESULT_W-1] ? ACC_MIN : ACC_MAX;
        end
    end

    assign w_s2_emit  = r_s2_valid && (r_s2_empty || r_s2_last);
    assign w_out_free = !r_out_valid || i_taken;
    assign w_s2_adv   = !w_s2_emit || w_out_free;
    assign w_do_acc   = w_s2_adv && r_s2_valid && !r_s2_empty;

    always_comb begin
        n_acc = r_acc;
        if (w_do_acc) begin
            n_acc = r_s2_last ? '0 : w_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid  <= 1'b0;
            r_acc       <= '0;
            r_row       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_acc <= n_acc;
            if (w_s2_adv) begin
                r_s2_valid <= i_req.valid;
            end
            if (w_s2_adv && w_s2_emit) begin
                r_out_valid <= 1'b1;
                r_row       <= r_row + ROW_W'(1);
            end else if (i_taken) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s2_adv) begin
            r_s2_empty <= i_req.empty_row;
            r_s2_last  <= i_req.last;
            r_prod     <= w_prod;
        end
        if (w_s2_adv && w_s2_emit) begin
            r_out_row <= r_row;
            r_out_res <= r_s2_empty ? '0 : w_sum;
        end
    end

    assign o_ready      = w_s2_adv;
    assign o_valid      = r_out_valid;
    assign o_row_index  = r_out_row;
    assign o_row_result = r_out_res;

endmodule
